// File: hdl/efc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the elevator floor controller.
// No dependencies; imported by every module of the block.
package efc_pkg;

  localparam int FLOORS_DEF      = 4;
  localparam int FLOOR_W         = 4;
  localparam int MASK_W          = 16;
  localparam int TICK_W          = 16;
  localparam logic [TICK_W-1:0] BLINK_TICKS_RST = 16'd500;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_SENSOR = 2'd1,
    MODE_EXEC   = 2'd2,
    MODE_START  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_INIT = 2'd0,
    ST_IDLE = 2'd1,
    ST_MOVE = 2'd2,
    ST_STOP = 2'd3
  } ctrl_state_t;

  typedef enum logic [2:0] {
    ARW_NONE   = 3'd0,
    ARW_UP_ON  = 3'd1,
    ARW_UP_OFF = 3'd2,
    ARW_DN_ON  = 3'd3,
    ARW_DN_OFF = 3'd4
  } arrow_t;

  // First member lands in the top bits: state_code ends up at bit 0.
  typedef struct packed {
    arrow_t              arrow_code;
    logic                blink;
    logic                buzzer_pulse;
    logic                motor_up;
    logic                motor_run;
    logic                destination_valid;
    logic [FLOOR_W-1:0]  destination_floor;
    logic                current_known;
    logic [FLOOR_W-1:0]  current_floor;
    ctrl_state_t         state_code;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// File: hdl/efc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: state registers, blink counter and the
// combinational update that forms one result per transfer. Uses efc_pkg.
module efc_ctrl
  import efc_pkg::*;
#(
  parameter int FLOORS = FLOORS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [TICK_W-1:0]  cfg_blink_ticks,
  input  logic               item_fire,
  input  mode_t              item_mode,
  input  logic [FLOOR_W-1:0] item_sensor_floor,
  input  logic [MASK_W-1:0]  item_button_mask,
  input  logic [MASK_W-1:0]  item_sensor_mask,
  output result_t            result
);

  localparam logic [MASK_W-1:0] FLOOR_MASK = MASK_W'((32'd1 << FLOORS) - 32'd1);

  ctrl_state_t        state_r, state_nxt;
  logic [FLOOR_W-1:0] floor_r, floor_nxt;
  logic               known_r, known_nxt;
  logic [FLOOR_W-1:0] target_r, target_nxt;
  logic               tset_r, tset_nxt;
  logic               motor_r, motor_nxt;
  logic               up_r, up_nxt;
  logic               blink_r, blink_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [TICK_W-1:0]  blink_ticks_r;

  logic [MASK_W-1:0]  start_bits;
  logic [FLOOR_W-1:0] start_floor;
  logic               start_hit;
  logic [MASK_W-1:0]  exec_bits;
  logic [FLOOR_W-1:0] exec_floor;
  logic               exec_hit;
  logic [TICK_W:0]    tick_inc;
  logic               buzz;
  logic               arrow_up;

  // Lowest blocked floor for start.
  always_comb begin
    start_bits  = item_sensor_mask & FLOOR_MASK;
    start_floor = '0;
    start_hit   = 1'b0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (start_bits[i]) begin
        start_floor = FLOOR_W'(i);
        start_hit   = 1'b1;
      end
    end
  end

  // Highest pushed floor other than the known current one.
  always_comb begin
    exec_bits = item_button_mask & FLOOR_MASK;
    if (known_r) begin
      exec_bits = exec_bits & ~(MASK_W'(1) << floor_r);
    end
    exec_floor = '0;
    exec_hit   = 1'b0;
    for (int i = 0; i < MASK_W; i++) begin
      if (exec_bits[i]) begin
        exec_floor = FLOOR_W'(i);
        exec_hit   = 1'b1;
      end
    end
  end

  assign tick_inc = {1'b0, tick_r} + (TICK_W+1)'(1);

  always_comb begin
    state_nxt  = state_r;
    floor_nxt  = floor_r;
    known_nxt  = known_r;
    target_nxt = target_r;
    tset_nxt   = tset_r;
    motor_nxt  = motor_r;
    up_nxt     = up_r;
    blink_nxt  = blink_r;
    tick_nxt   = tick_r;
    buzz       = 1'b0;
    unique case (item_mode)
      MODE_TICK: begin
        if (state_r == ST_MOVE) begin
          if (tick_inc >= {1'b0, blink_ticks_r}) begin
            tick_nxt  = '0;
            blink_nxt = ~blink_r;
          end else begin
            tick_nxt = tick_inc[TICK_W-1:0];
          end
        end
      end
      MODE_SENSOR: begin
        if (32'(item_sensor_floor) < FLOORS) begin
          floor_nxt = item_sensor_floor;
          known_nxt = 1'b1;
          if (tset_r && target_r == item_sensor_floor) begin
            motor_nxt  = 1'b0;
            tset_nxt   = 1'b0;
            target_nxt = '0;
            state_nxt  = ST_STOP;
          end
        end
      end
      MODE_EXEC: begin
        if (state_r == ST_STOP) begin
          state_nxt = ST_IDLE;
          buzz      = 1'b1;
        end else if (state_r == ST_IDLE && exec_hit) begin
          target_nxt = exec_floor;
          tset_nxt   = 1'b1;
          up_nxt     = !known_r || exec_floor > floor_r;
          motor_nxt  = 1'b1;
          state_nxt  = ST_MOVE;
        end
      end
      MODE_START: begin
        floor_nxt  = start_floor;
        known_nxt  = start_hit;
        target_nxt = '0;
        if (start_hit && start_floor == '0) begin
          state_nxt = ST_IDLE;
          tset_nxt  = 1'b0;
          motor_nxt = 1'b0;
        end else begin
          // home downward toward floor 0
          state_nxt = ST_INIT;
          tset_nxt  = 1'b1;
          up_nxt    = 1'b0;
          motor_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result reflects the state after this transfer.
  always_comb begin
    arrow_up                 = tset_nxt && (!known_nxt || target_nxt > floor_nxt);
    result.state_code        = state_nxt;
    result.current_floor     = known_nxt ? floor_nxt : '0;
    result.current_known     = known_nxt;
    result.destination_floor = tset_nxt ? target_nxt : '0;
    result.destination_valid = tset_nxt;
    result.motor_run         = motor_nxt;
    result.motor_up          = up_nxt;
    result.buzzer_pulse      = buzz;
    result.blink             = blink_nxt;
    if (state_nxt != ST_MOVE) begin
      result.arrow_code = ARW_NONE;
    end else if (arrow_up) begin
      result.arrow_code = blink_nxt ? ARW_UP_ON : ARW_UP_OFF;
    end else begin
      result.arrow_code = blink_nxt ? ARW_DN_ON : ARW_DN_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      floor_r  <= '0;
      known_r  <= 1'b0;
      target_r <= '0;
      tset_r   <= 1'b0;
      motor_r  <= 1'b0;
      up_r     <= 1'b0;
      blink_r  <= 1'b0;
      tick_r   <= '0;
    end else if (item_fire) begin
      state_r  <= state_nxt;
      floor_r  <= floor_nxt;
      known_r  <= known_nxt;
      target_r <= target_nxt;
      tset_r   <= tset_nxt;
      motor_r  <= motor_nxt;
      up_r     <= up_nxt;
      blink_r  <= blink_nxt;
      tick_r   <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_ticks_r <= BLINK_TICKS_RST;
    end else if (cfg_we) begin
      blink_ticks_r <= cfg_blink_ticks;
    end
  end

  // Idle and stop never drive the motor.
  a_rest_motor_off: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_STOP) |-> !motor_r)
    else $error("motor driven while at rest");

  // Idle never holds a destination.
  a_idle_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !tset_r)
    else $error("destination held in idle");

  // Counter stays cleared outside move unless a move was left mid-count.
  a_tick_only_move: assert property (@(posedge clk) disable iff (!rst_n)
    (item_fire && item_mode == MODE_TICK && state_r != ST_MOVE) |=>
      $stable(tick_r) && $stable(blink_r))
    else $error("blink counter advanced outside move");

endmodule

// File: hdl/efc_out_reg.sv
`timescale 1ns / 1ps
// Result register: holds one result until the downstream side takes it and
// accepts a new one in the same cycle. Uses efc_pkg for result_t.
module efc_out_reg
  import efc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  input  logic    take,
  output logic    room,
  output logic    vld,
  output result_t data
);

  logic    vld_r, vld_nxt;
  result_t data_r;

  assign room = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign vld  = vld_r;
  assign data = data_r;

  // A load only happens when the slot is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!vld_r || take))
    else $error("result overwritten before transfer");

  // Held result stays put while not taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !take && !load) |=> vld_r && $stable(data_r))
    else $error("held result changed");

endmodule

// File: hdl/elevator_floor_controller.sv
`timescale 1ns / 1ps
// Elevator floor controller. Every input transfer (tick, floor sensor, execute
// with buttons, start with sensors) yields exactly one result transfer with the
// motor controls, floors, state and arrow code after that item. The state update
// is a single combinational pass into a result register, so a new item is taken
// every cycle while the result register is empty or being drained, and its result
// is offered the cycle after. A waiting result with out_tready low holds in_tready
// low. The blink period is written through the cfg port (reset 500 ticks); the user
// must write it only while the block is idle, as the block does not enforce this.
// Depends on efc_pkg, efc_ctrl and efc_out_reg.
module elevator_floor_controller
  import efc_pkg::*;
#(
  parameter int FLOORS = FLOORS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [3:0] sensor_floor, [19:4] button_mask, [35:20] sensor_mask, [39:36] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] mode
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] state_code, [5:2] current_floor, [6] current_known,
  // [10:7] destination_floor, [11] destination_valid, [12] motor_run,
  // [13] motor_up, [14] buzzer_pulse, [15] blink, [18:16] arrow_code, [23:19] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TICK_W-1:0]     cfg_data
);

  logic    in_fire;
  logic    room;
  result_t step_res;
  result_t held_res;

  assign cfg_ready = 1'b1;
  assign in_tready = room;
  assign in_fire   = in_tvalid && in_tready;

  efc_ctrl #(
    .FLOORS(FLOORS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_blink_ticks  (cfg_data),
    .item_fire        (in_fire),
    .item_mode        (mode_t'(in_tuser)),
    .item_sensor_floor(in_tdata[3:0]),
    .item_button_mask (in_tdata[19:4]),
    .item_sensor_mask (in_tdata[35:20]),
    .result           (step_res)
  );

  efc_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_fire),
    .load_data(step_res),
    .take     (out_tready),
    .room     (room),
    .vld      (out_tvalid),
    .data     (held_res)
  );

  assign out_tdata = {(OUT_DATA_W - RESULT_W)'(0), held_res};

  // Stalled input only while a result waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without pending result");

  // Arrow shows only while moving.
  a_arrow_move: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && held_res.state_code != ST_MOVE) |-> held_res.arrow_code == ARW_NONE)
    else $error("arrow shown outside move");

  // Buzzer pulses only on the return to idle.
  a_buzz_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && held_res.buzzer_pulse) |-> held_res.state_code == ST_IDLE)
    else $error("buzzer outside return to idle");

endmodule

// File: tb/sv/elevator_floor_controller_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for elevator_floor_controller: a directed table, then
// state-aware random items under sender and receiver stalls, checked field by field
// against a cycle-free predictor. Depends on efc_pkg and the controller RTL.
module elevator_floor_controller_test;
  import efc_pkg::*;

  localparam int NUM_FLOORS  = FLOORS_DEF;
  localparam int CYCLE_LIMIT = 50000;
  localparam int PHASE_ITEMS = 135;

  typedef struct {
    mode_t              mode;
    logic [FLOOR_W-1:0] sfloor;
    logic [MASK_W-1:0]  buttons;
    logic [MASK_W-1:0]  sensors;
    bit                 typed;
    result_t            want;
  } stim_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [TICK_W-1:0]     cfg_data   = '0;

  // Predicted controller state
  ctrl_state_t        car_state      = ST_INIT;
  logic [FLOOR_W-1:0] car_floor      = '0;
  logic               car_known      = 1'b0;
  logic [FLOOR_W-1:0] car_target     = '0;
  logic               car_target_set = 1'b0;
  logic               car_motor      = 1'b0;
  logic               car_up         = 1'b0;
  logic               car_blink      = 1'b0;
  logic [TICK_W-1:0]  car_ticks      = '0;
  logic [TICK_W-1:0]  car_period     = BLINK_TICKS_RST;

  result_t   pending_results[$];
  stim_row_t directed_rows[$];
  int errors    = 0;
  int checked   = 0;
  int buzzes    = 0;
  int toggles   = 0;
  int sent      = 0;
  int cycles    = 0;
  int send_idle = 0;
  int recv_idle = 0;

  elevator_floor_controller #(
    .FLOORS(NUM_FLOORS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results pending", $time,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic result_t mk_result(ctrl_state_t st, logic [FLOOR_W-1:0] cf, logic ck,
                                        logic [FLOOR_W-1:0] df, logic dv, logic run,
                                        logic up, logic buzz, logic bl, arrow_t ar);
    result_t r;
    r.state_code        = st;
    r.current_floor     = cf;
    r.current_known     = ck;
    r.destination_floor = df;
    r.destination_valid = dv;
    r.motor_run         = run;
    r.motor_up          = up;
    r.buzzer_pulse      = buzz;
    r.blink             = bl;
    r.arrow_code        = ar;
    return r;
  endfunction

  // Apply one item to the predicted state and form the result it yields.
  task automatic advance_controller(input mode_t md, input logic [FLOOR_W-1:0] sf,
                                    input logic [MASK_W-1:0] bm,
                                    input logic [MASK_W-1:0] sm, output result_t res);
    logic          buzz;
    logic          found;
    logic          heading_up;
    logic [TICK_W:0] nxt;
    arrow_t        arrow;
    buzz  = 1'b0;
    found = 1'b0;
    case (md)
      MODE_TICK: begin
        if (car_state == ST_MOVE) begin
          nxt = {1'b0, car_ticks} + (TICK_W+1)'(1);
          if (nxt >= {1'b0, car_period}) begin
            car_ticks = '0;
            car_blink = !car_blink;
            toggles++;
          end else begin
            car_ticks = nxt[TICK_W-1:0];
          end
        end
      end
      MODE_SENSOR: begin
        if (32'(sf) < NUM_FLOORS) begin
          car_floor = sf;
          car_known = 1'b1;
          if (car_target_set && car_target == sf) begin
            car_motor      = 1'b0;
            car_target_set = 1'b0;
            car_target     = '0;
            car_state      = ST_STOP;
          end
        end
      end
      MODE_EXEC: begin
        if (car_state == ST_STOP) begin
          car_state = ST_IDLE;
          buzz      = 1'b1;
        end else if (car_state == ST_IDLE) begin
          // highest pushed floor other than the current one wins
          for (int f = NUM_FLOORS - 1; f >= 0; f--) begin
            if (!found && bm[f] && (!car_known || FLOOR_W'(f) != car_floor)) begin
              found          = 1'b1;
              car_target     = FLOOR_W'(f);
              car_target_set = 1'b1;
              car_up         = !car_known || (FLOOR_W'(f) > car_floor);
              car_motor      = 1'b1;
              car_state      = ST_MOVE;
            end
          end
        end
      end
      default: begin
        car_known = 1'b0;
        car_floor = '0;
        for (int f = 0; f < NUM_FLOORS; f++) begin
          if (!found && sm[f]) begin
            found     = 1'b1;
            car_floor = FLOOR_W'(f);
            car_known = 1'b1;
          end
        end
        car_target     = '0;
        car_target_set = 1'b0;
        if (car_known && car_floor == 0) begin
          car_state = ST_IDLE;
          car_motor = 1'b0;
        end else begin
          // home downward to floor 0
          car_state      = ST_INIT;
          car_target_set = 1'b1;
          car_up         = 1'b0;
          car_motor      = 1'b1;
        end
      end
    endcase

    arrow = ARW_NONE;
    if (car_state == ST_MOVE) begin
      heading_up = car_target_set && (!car_known || car_target > car_floor);
      if (heading_up) arrow = car_blink ? ARW_UP_ON : ARW_UP_OFF;
      else            arrow = car_blink ? ARW_DN_ON : ARW_DN_OFF;
    end
    res = mk_result(car_state, car_known ? car_floor : '0, car_known,
                    car_target_set ? car_target : '0, car_target_set, car_motor,
                    car_up, buzz, car_blink, arrow);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[RESULT_W-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer %h with nothing expected", $time, out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (got.buzzer_pulse) buzzes++;
        check_field("state_code", 16'(want.state_code), 16'(got.state_code));
        check_field("current_floor", 16'(want.current_floor), 16'(got.current_floor));
        check_field("current_known", 16'(want.current_known), 16'(got.current_known));
        check_field("destination_floor", 16'(want.destination_floor),
                    16'(got.destination_floor));
        check_field("destination_valid", 16'(want.destination_valid),
                    16'(got.destination_valid));
        check_field("motor_run", 16'(want.motor_run), 16'(got.motor_run));
        check_field("motor_up", 16'(want.motor_up), 16'(got.motor_up));
        check_field("buzzer_pulse", 16'(want.buzzer_pulse), 16'(got.buzzer_pulse));
        check_field("blink", 16'(want.blink), 16'(got.blink));
        check_field("arrow_code", 16'(want.arrow_code), 16'(got.arrow_code));
        check_field("tdata pad", '0, 16'(out_tdata[OUT_DATA_W-1:RESULT_W]));
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_item(input mode_t md, input logic [FLOOR_W-1:0] sf,
                           input logic [MASK_W-1:0] bm, input logic [MASK_W-1:0] sm,
                           input bit typed, input result_t want);
    result_t predicted;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= md;
    in_tdata  <= {4'b0, sm, bm, sf};
    do @(posedge clk); while (!in_tready);
    advance_controller(md, sf, bm, sm, predicted);
    pending_results.push_back(typed ? want : predicted);
    sent++;
  endtask

  // Hold the sender until every expected result has been taken.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_period(input logic [TICK_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    car_period = value;
    @(posedge clk);
  endtask

  task automatic add_row(input mode_t md, input logic [FLOOR_W-1:0] sf,
                         input logic [MASK_W-1:0] bm, input logic [MASK_W-1:0] sm,
                         input bit typed, input result_t want);
    stim_row_t row;
    row.mode    = md;
    row.sfloor  = sf;
    row.buttons = bm;
    row.sensors = sm;
    row.typed   = typed;
    row.want    = want;
    directed_rows.push_back(row);
  endtask

  // Random items weighted by the predicted state so runs get through
  // homing, moves, arrivals and buzzer returns; the rest is noise.
  task automatic run_random(input int count, input int s_idle, input int r_idle,
                            input int pause_at);
    mode_t              md;
    logic [FLOOR_W-1:0] sf;
    logic [MASK_W-1:0]  bm;
    logic [MASK_W-1:0]  sm;
    int                 r;
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int k = 0; k < count; k++) begin
      if (k == pause_at) wait_drained();
      r = $urandom_range(99);
      case (car_state)
        ST_INIT: begin
          if (r < 60)      md = MODE_SENSOR;
          else if (r < 75) md = MODE_TICK;
          else if (r < 90) md = MODE_EXEC;
          else             md = MODE_START;
        end
        ST_IDLE: begin
          if (r < 65)      md = MODE_EXEC;
          else if (r < 80) md = MODE_START;
          else if (r < 90) md = MODE_SENSOR;
          else             md = MODE_TICK;
        end
        ST_MOVE: begin
          if (r < 55)      md = MODE_TICK;
          else if (r < 90) md = MODE_SENSOR;
          else if (r < 95) md = MODE_EXEC;
          else             md = MODE_START;
        end
        default: begin
          if (r < 75)      md = MODE_EXEC;
          else if (r < 85) md = MODE_TICK;
          else if (r < 95) md = MODE_SENSOR;
          else             md = MODE_START;
        end
      endcase
      r = $urandom_range(99);
      if (car_target_set && r < 40) sf = car_target;
      else if (r < 85)              sf = FLOOR_W'($urandom_range(NUM_FLOORS - 1));
      else                          sf = FLOOR_W'($urandom_range(15));
      bm = MASK_W'($urandom);
      if ($urandom_range(99) < 15) bm = '0;
      sm = MASK_W'($urandom);
      r = $urandom_range(99);
      if (r < 40)      sm = sm | 16'h0001;
      else if (r < 55) sm = '0;
      else if (r < 65) sm = sm & 16'hfff0;
      send_item(md, sf, bm, sm, 1'b0, '0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short blink period so the table sees toggles
    write_period(16'd2);
    add_row(MODE_TICK, 4'd0, 16'h0000, 16'h0000, 1'b1,
            mk_result(ST_INIT, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ARW_NONE));
    add_row(MODE_EXEC, 4'd0, 16'hffff, 16'h0000, 1'b1,
            mk_result(ST_INIT, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ARW_NONE));
    add_row(MODE_START, 4'd0, 16'h0000, 16'h0000, 1'b1,
            mk_result(ST_INIT, 4'd0, 1'b0, 4'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ARW_NONE));
    add_row(MODE_SENSOR, 4'd15, 16'h0000, 16'h0000, 1'b1,
            mk_result(ST_INIT, 4'd0, 1'b0, 4'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ARW_NONE));
    add_row(MODE_SENSOR, 4'd2, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(MODE_SENSOR, 4'd0, 16'h0000, 16'h0000, 1'b1,
            mk_result(ST_STOP, 4'd0, 1'b1, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ARW_NONE));
    add_row(MODE_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(MODE_EXEC, 4'd0, 16'h0000, 16'h0000, 1'b1,
            mk_result(ST_IDLE, 4'd0, 1'b1, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, ARW_NONE));
    add_row(MODE_EXEC, 4'd0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(MODE_EXEC, 4'd0, 16'h0001, 16'h0000, 1'b0, '0);
    add_row(MODE_EXEC, 4'd0, 16'hffff, 16'h0000, 1'b0, '0);
    add_row(MODE_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(MODE_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(MODE_EXEC, 4'd0, 16'h0004, 16'h0000, 1'b0, '0);
    add_row(MODE_SENSOR, 4'd1, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(MODE_SENSOR, 4'd3, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(MODE_EXEC, 4'd0, 16'hffff, 16'h0000, 1'b0, '0);
    add_row(MODE_EXEC, 4'd0, 16'h0001, 16'h0000, 1'b0, '0);
    add_row(MODE_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(MODE_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(MODE_START, 4'd0, 16'h0000, 16'hfff0, 1'b0, '0);
    add_row(MODE_START, 4'd0, 16'h0000, 16'h0004, 1'b0, '0);
    add_row(MODE_START, 4'd0, 16'h0000, 16'hffff, 1'b0, '0);
    add_row(MODE_SENSOR, 4'd0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(MODE_EXEC, 4'd0, 16'h8002, 16'h0000, 1'b0, '0);
    foreach (directed_rows[i])
      send_item(directed_rows[i].mode, directed_rows[i].sfloor, directed_rows[i].buttons,
                directed_rows[i].sensors, directed_rows[i].typed, directed_rows[i].want);
    wait_drained();

    write_period(16'd1);
    run_random(PHASE_ITEMS, 28, 53, 60);
    wait_drained();
    // longest period: the running count climbs, then the next write lowers it
    write_period(16'hffff);
    run_random(PHASE_ITEMS, 53, 28, -1);
    wait_drained();
    write_period(16'd4);
    run_random(PHASE_ITEMS, 0, 0, -1);
    wait_drained();
    repeat (8) @(posedge clk);

    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors += pending_results.size();
    end
    $display("Covered %0d items (%0d from the table) under three stall mixes, four periods.",
             sent, directed_rows.size());
    $display("Checked %0d results: %0d buzzer pulses, %0d blink toggles, %0d errors.",
             checked, buzzes, toggles, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
